### hdl/font_descriptor_parser_top_assert.svh
// Assertion macros for the font descriptor parser
`ifndef FONT_DESCRIPTOR_PARSER_TOP_ASSERT_SVH
`define FONT_DESCRIPTOR_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdp assertion failed");

// Next-cycle implication, checked outside reset
`define FDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdp assertion failed");

`endif

### hdl/fdp_pkg.sv
// Shared constants, types and helpers for the font descriptor parser
`default_nettype none

package fdp_pkg;

   // Line length limit and derived widths
   localparam int MAX_LEN = 256;
   localparam int CNT_W   = $clog2(MAX_LEN + 2);
   localparam int CHAR_W  = 8;
   localparam int PTR_W   = 8;
   localparam int FLEN_W  = 9;
   localparam int PX_W    = 16;
   localparam int NV_W    = PX_W + 4;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   localparam logic [PX_W-1:0] MAX_PX_RESET = 16'd255;

   // One result transaction
   typedef struct packed {
      logic              parse_ok;
      logic [PTR_W-1:0]  face_start;
      logic [FLEN_W-1:0] face_length;
      logic [PX_W-1:0]   size_px;
   } result_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

`default_nettype wire

### hdl/font_descriptor_parser_top.sv
// A character is registered on acceptance and then processed from that register by fdp_scan;
// the result of a line is registered onto rsp_ when its last character leaves the input register.
// Throughput: one character per cycle, set by the state update in fdp_scan;
// a line end waits only while the previous result is still held on rsp_.
// Reset (synchronous, active high) clears line state and valids and sets max_px to 255.
`default_nettype none

`include "font_descriptor_parser_top_assert.svh"

module font_descriptor_parser_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input channel
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [fdp_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic                        req_last_char,
   // result channel
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_parse_ok,
   output      logic [fdp_pkg::PTR_W-1:0]   rsp_face_start,
   output      logic [fdp_pkg::FLEN_W-1:0]  rsp_face_length,
   output      logic [fdp_pkg::PX_W-1:0]    rsp_size_px,
   // configuration
   input  wire logic                        csr_write_enable,
   input  wire logic [fdp_pkg::PX_W-1:0]    csr_write_data
);

   logic                        in_valid_ff;
   logic [fdp_pkg::CHAR_W-1:0]  in_char_ff;
   logic                        in_last_ff;
   logic [fdp_pkg::PX_W-1:0]    max_px_ff;
   logic                        out_valid_ff;
   fdp_pkg::result_type         out_ff;
   fdp_pkg::result_type         scan_result;
   logic                        advance;

   // Stage moves unless a line end would overwrite an untaken result
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_px_ff <= fdp_pkg::MAX_PX_RESET;
      end else if (csr_write_enable) begin
         max_px_ff <= csr_write_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   fdp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .max_px    (max_px_ff),
      .result    (scan_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_ff <= scan_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_parse_ok    = out_ff.parse_ok;
   assign rsp_face_start  = out_ff.face_start;
   assign rsp_face_length = out_ff.face_length;
   assign rsp_size_px     = out_ff.size_px;

   // Checks
   `FDP_ASSERT_NOW(a_fail_zero, clock, reset, out_valid_ff && !out_ff.parse_ok,
      out_ff.size_px == '0 && out_ff.face_length == '0 && out_ff.face_start == '0)
   `FDP_ASSERT_NOW(a_ok_size, clock, reset, out_valid_ff && out_ff.parse_ok,
      out_ff.size_px != '0 && out_ff.size_px <= max_px_ff)
   `FDP_ASSERT_NOW(a_no_overwrite, clock, reset,
      in_valid_ff && in_last_ff && out_valid_ff && !rsp_ready, !advance && !req_ready)
   `FDP_ASSERT_NEXT(a_line_end, clock, reset, advance && in_last_ff, out_valid_ff)

endmodule

`default_nettype wire

### hdl/fdp_scan.sv
// Per-character line state and end-of-line result evaluation
`default_nettype none

module fdp_scan (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [fdp_pkg::CHAR_W-1:0] char_code,
   input  wire logic                       last_char,
   input  wire logic [fdp_pkg::PX_W-1:0]   max_px,
   output fdp_pkg::result_type             result
);

   localparam logic [fdp_pkg::CNT_W-1:0] LEN_LIMIT = fdp_pkg::CNT_W'(fdp_pkg::MAX_LEN);

   // Line state registers
   logic [fdp_pkg::CNT_W-1:0]  position_ff, position_in;
   logic [fdp_pkg::PTR_W-1:0]  first_pos_ff, first_pos_in;
   logic                       seen_ff, seen_in;
   logic                       in_token_ff, in_token_in;
   logic [fdp_pkg::PTR_W-1:0]  prev_end_ff, prev_end_in;
   logic                       have_prev_ff, have_prev_in;
   logic [fdp_pkg::PTR_W-1:0]  cur_end_ff, cur_end_in;
   logic [fdp_pkg::CNT_W-1:0]  tok_len_ff, tok_len_in;
   logic [fdp_pkg::PX_W-1:0]   val_ff, val_in;
   logic [fdp_pkg::PX_W-1:0]   val_b1_ff, val_b1_in;
   logic [fdp_pkg::PX_W-1:0]   val_b2_ff, val_b2_in;
   logic [2:0]                 flags_ff, flags_in;
   logic [2*fdp_pkg::CHAR_W-1:0] tail_ff, tail_in;

   // Token base values (fresh when a token starts)
   logic                         starting;
   logic [fdp_pkg::CNT_W-1:0]    b_len;
   logic [fdp_pkg::PX_W-1:0]     b_val, b_val1;
   logic [2:0]                   b_flags;
   logic [2*fdp_pkg::CHAR_W-1:0] b_tail;
   logic                         digit;
   logic [fdp_pkg::NV_W-1:0]     nv;
   logic                         dig_ok;

   // End-of-line evaluation
   logic                         has_px;
   logic [fdp_pkg::CNT_W-1:0]    size_len;
   logic [fdp_pkg::PX_W-1:0]     size_val;
   logic                         size_vok;
   logic                         ok;

   always_comb begin
      starting = !fdp_pkg::is_blank(char_code) && !in_token_ff;
      b_len    = starting ? '0 : tok_len_ff;
      b_val    = starting ? '0 : val_ff;
      b_val1   = starting ? '0 : val_b1_ff;
      b_flags  = starting ? 3'b111 : flags_ff;
      b_tail   = starting ? '0 : tail_ff;
      digit    = (char_code >= fdp_pkg::CH_ZERO) && (char_code <= fdp_pkg::CH_NINE);
      // times ten plus digit, as two shifts and adds
      nv = ({4'b0, b_val} << 3) + ({4'b0, b_val} << 1) +
           (digit ? fdp_pkg::NV_W'(char_code - fdp_pkg::CH_ZERO) : '0);
      dig_ok = b_flags[0] && digit && (nv <= {4'b0, max_px});
   end

   // Next state for one character
   always_comb begin
      position_in  = (position_ff <= LEN_LIMIT) ? position_ff + 1'b1 : position_ff;
      first_pos_in = first_pos_ff;
      seen_in      = seen_ff;
      in_token_in  = in_token_ff;
      prev_end_in  = prev_end_ff;
      have_prev_in = have_prev_ff;
      cur_end_in   = cur_end_ff;
      tok_len_in   = tok_len_ff;
      val_in       = val_ff;
      val_b1_in    = val_b1_ff;
      val_b2_in    = val_b2_ff;
      flags_in     = flags_ff;
      tail_in      = tail_ff;
      if (fdp_pkg::is_blank(char_code)) begin
         in_token_in = 1'b0;
      end else begin
         if (starting) begin
            if (seen_ff) begin
               prev_end_in  = cur_end_ff;
               have_prev_in = 1'b1;
            end else begin
               first_pos_in = position_ff[fdp_pkg::PTR_W-1:0];
               seen_in      = 1'b1;
            end
         end
         in_token_in = 1'b1;
         val_b2_in   = b_val1;
         val_b1_in   = b_val;
         val_in      = (nv > fdp_pkg::NV_W'(16'hFFFF)) ? 16'hFFFF
                                                      : nv[fdp_pkg::PX_W-1:0];
         flags_in    = {b_flags[1:0], dig_ok};
         tok_len_in  = (b_len <= LEN_LIMIT) ? b_len + 1'b1 : b_len;
         tail_in     = {b_tail[fdp_pkg::CHAR_W-1:0], char_code};
         cur_end_in  = position_ff[fdp_pkg::PTR_W-1:0] + 1'b1;
      end
   end

   // Result from the state after this character
   always_comb begin
      has_px = (tok_len_in >= fdp_pkg::CNT_W'(2)) &&
               (tail_in == {fdp_pkg::CH_P, fdp_pkg::CH_X});
      if (has_px) begin
         size_len = tok_len_in - fdp_pkg::CNT_W'(2);
         size_val = val_b2_in;
         size_vok = flags_in[2];
      end else begin
         size_len = tok_len_in;
         size_val = val_in;
         size_vok = flags_in[0];
      end
      ok = have_prev_in && (position_in <= LEN_LIMIT) && (size_len != '0) &&
           size_vok && (size_val != '0);
      result.parse_ok    = ok;
      result.face_start  = ok ? first_pos_in : '0;
      result.face_length = ok ? ({1'b0, prev_end_in} - {1'b0, first_pos_in}) : '0;
      result.size_px     = ok ? size_val : '0;
   end

   // State registers; end of line returns to the cleared state
   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         position_ff  <= '0;
         first_pos_ff <= '0;
         seen_ff      <= 1'b0;
         in_token_ff  <= 1'b0;
         prev_end_ff  <= '0;
         have_prev_ff <= 1'b0;
         cur_end_ff   <= '0;
         tok_len_ff   <= '0;
         val_ff       <= '0;
         val_b1_ff    <= '0;
         val_b2_ff    <= '0;
         flags_ff     <= 3'b111;
         tail_ff      <= '0;
      end else if (step) begin
         position_ff  <= position_in;
         first_pos_ff <= first_pos_in;
         seen_ff      <= seen_in;
         in_token_ff  <= in_token_in;
         prev_end_ff  <= prev_end_in;
         have_prev_ff <= have_prev_in;
         cur_end_ff   <= cur_end_in;
         tok_len_ff   <= tok_len_in;
         val_ff       <= val_in;
         val_b1_ff    <= val_b1_in;
         val_b2_ff    <= val_b2_in;
         flags_ff     <= flags_in;
         tail_ff      <= tail_in;
      end
   end

endmodule

`default_nettype wire
